>>> hw/rtl/iwo_pkg.sv
// ----------------------------------------------------------------------------
// iwo_pkg: shared types and constants of the wavetable oscillator
// Sequencer states, action codes and widths of the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package iwo_pkg;

  // Action codes carried on the input tuser bit
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Fixed field widths
  localparam int unsigned IDX_FIELD_W = 10;
  localparam int unsigned SMP_W       = 16;
  localparam int unsigned CTRL_W      = 10;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 32;

  // Shared multiplier: signed sample by unsigned weight (up to amp*8)
  localparam int unsigned MUL_A_W = SMP_W;
  localparam int unsigned MUL_B_W = 13;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W + 1;

  // Offset-binary midpoint
  localparam logic [SMP_W-1:0] MID_OFFSET = 16'h7fff;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_BLEND,
    ST_SCALE,
    ST_DONE
  } iwo_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/interpolating_wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// interpolating_wavetable_oscillator: DDS oscillator with linear interpolation
// Phase accumulator addresses a waveform memory; two neighboring words are
// blended by the phase fraction, scaled by amplitude and sent out as a
// normal and an inverted offset-binary channel.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  in_      | in  | index, value, freq, amp (48 bits)       | action
//  out_     | out | chan_a, chan_b (32 bits)                | -
//
//  A write item leaves the sequencer idle, so in_tready stays high.
//  A tick item keeps in_tready low until its result loads into the output
//  register, so no new item is taken meanwhile; the result passes READ_A,
//  READ_B, BLEND, SCALE and DONE. Two reads of the single-port waveform
//  memory overlap with three passes of one multiplier.
//  The result loads into an output register; a stall there holds the
//  sequencer in its last state and input tready stays low.
//  Reset clears the phase and the control state, not the waveform memory.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolating_wavetable_oscillator #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // [9:0] table_index, [25:10] table_value, [35:26] freq_control,
  // [45:36] amp_control, [47:46] zero
  input  wire logic [iwo_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] action
  input  wire logic                               in_tuser,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] chan_a, [31:16] chan_b
  output      logic [iwo_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import iwo_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned PH_W  = IDX_W + FRAC_BITS;

  iwo_state_t state_r, state_nxt;

  logic [PH_W-1:0]          phase_r;
  logic [CTRL_W-1:0]        amp_r;
  logic signed [SMP_W-1:0]  rd_data_r;
  logic [SMP_W-1:0]         acc_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_valid_r;

  logic signed [SMP_W-1:0]  mem [TABLE_DEPTH];

  logic [IDX_FIELD_W-1:0]   f_index;
  logic [SMP_W-1:0]         f_value;
  logic [CTRL_W-1:0]        f_freq;
  logic [CTRL_W-1:0]        f_amp;

  logic                     accept;
  logic                     take_tick;
  logic                     take_write;
  logic [MUL_B_W-1:0]       step;
  logic [PH_W-1:0]          phase_nxt;
  logic [IDX_W-1:0]         rd_idx;
  logic [IDX_W-1:0]         cur_idx;
  logic [FRAC_BITS-1:0]     frac;
  logic [FRAC_BITS-1:0]     frac_inv;
  logic                     rd_en;
  logic                     mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SMP_W-1:0]         term;
  logic [SMP_W-1:0]         blend;
  logic [SMP_W-1:0]         scaled;
  logic                     out_load;

  // Unpack the input item
  assign f_index = in_tdata[9:0];
  assign f_value = in_tdata[25:10];
  assign f_freq  = in_tdata[35:26];
  assign f_amp   = in_tdata[45:36];

  assign accept     = in_tvalid && in_tready;
  assign take_tick  = accept && (in_tuser == ACT_TICK);
  assign take_write = accept && (in_tuser == ACT_WRITE);

  // Advance the phase by 1 + freq*8, wrapping at the phase width
  assign step      = MUL_B_W'(1) + {f_freq, 3'b000};
  assign phase_nxt = phase_r + PH_W'(step);

  assign cur_idx = phase_r[PH_W-1:FRAC_BITS];
  assign frac    = phase_r[FRAC_BITS-1:0];

  // F - frac is the bitwise complement of the fraction
  assign frac_inv = ~frac;

  // Floor-shifted product term, wrapped to 16 bits
  assign term   = SMP_W'(prod >>> FRAC_BITS);
  assign blend  = acc_r + term;
  assign scaled = SMP_W'(prod >>> 16);

  // Shared multiplier
  iwo_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // Sequencer: next state, memory read address and multiplier operands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = cur_idx;
    mul_en    = 1'b0;
    mul_a     = rd_data_r;
    mul_b     = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (take_tick) begin
          state_nxt = ST_READ_A;
        end
      end
      ST_READ_A: begin
        rd_en     = 1'b1;
        state_nxt = ST_READ_B;
      end
      ST_READ_B: begin
        // read the next word while the first one is weighted by F - frac
        rd_en     = 1'b1;
        rd_idx    = cur_idx + IDX_W'(1);
        mul_en    = 1'b1;
        mul_b     = MUL_B_W'(frac_inv);
        state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        mul_en    = 1'b1;
        mul_b     = MUL_B_W'(frac);
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        mul_en    = 1'b1;
        mul_a     = $signed(blend);
        mul_b     = {amp_r, 3'b000};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take_tick) begin
        phase_r <= phase_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take_tick) begin
      amp_r <= f_amp;
    end
    if (state_r == ST_BLEND) begin
      acc_r <= term;
    end
    if (out_load) begin
      out_data_r <= {MID_OFFSET - scaled, scaled + MID_OFFSET};
    end
  end

  // Waveform memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (take_write) begin
      mem[IDX_W'(f_index)] <= f_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A tick starts the read sequence
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take_tick |=> state_r == ST_READ_A)
    else $error("tick item did not start the read sequence");

  // Phase moves only on an accepted tick
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take_tick |=> $stable(phase_r))
    else $error("phase changed without a tick item");

  // A write item never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    take_write |=> !$rose(out_valid_r))
    else $error("write item produced a result");

  // A finished tick reaches the output register when it is free
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into free output register");

endmodule

`default_nettype wire

>>> hw/rtl/iwo_mul.sv
// ----------------------------------------------------------------------------
// iwo_mul: shared registered multiplier
// Signed sample times unsigned weight, product registered when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module iwo_mul (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic signed [iwo_pkg::MUL_A_W-1:0]     op_a,
  input  wire logic        [iwo_pkg::MUL_B_W-1:0]     op_b,
  output      logic signed [iwo_pkg::PROD_W-1:0]      prod_r
);
  import iwo_pkg::*;

  logic signed [MUL_B_W:0]  op_b_s;
  logic signed [PROD_W-1:0] prod_nxt;

  // Treat the weight as a non-negative signed operand
  assign op_b_s   = $signed({1'b0, op_b});
  assign prod_nxt = PROD_W'(op_a * op_b_s);

  // Hold the product until the next enabled step
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire
